/* rtl/mi3_pkg.sv */
// shared widths and constants for the 3x3 inverse transpose pipeline
package mi3_pkg;
  localparam int IN_W  = 16;
  localparam int OUT_W = 32;
  // cofactor carries 2F fraction bits, det 3F; result needs F+G more on the numerator
  localparam int SH    = (IN_W - 4) + OUT_W / 2;
  localparam int PW    = 2 * IN_W;
  localparam int CW    = 2 * IN_W + 1;
  localparam int DW    = 3 * IN_W + 3;
  localparam int RW    = DW + 1;
  localparam int QB    = OUT_W + 1;
  localparam int TW    = (CW + SH + 2 > RW + 1) ? (CW + SH + 2) : (RW + 1);
  localparam int COF_LAT  = 4;
  localparam int LANE_LAT = QB + 4;
  localparam int IN_DATA_W  = ((9 * IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((9 * OUT_W + 7) / 8) * 8;
endpackage

/* rtl/mi3_cofactor.sv */
// cofactor and determinant stages: products, differences, row 0 products, sum
module mi3_cofactor import mi3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IN_W-1:0] a [3][3],
  output logic                 out_valid,
  output logic signed [CW-1:0] cof [3][3],
  output logic signed [DW-1:0] det
);
  logic signed [PW-1:0]   p1 [3][3];
  logic signed [PW-1:0]   p2 [3][3];
  logic signed [CW-1:0]   c2 [3][3];
  logic signed [CW-1:0]   c3 [3][3];
  logic signed [DW-1:0]   dp [3];
  logic signed [IN_W-1:0] r0_1 [3];
  logic signed [IN_W-1:0] r0_2 [3];
  logic [COF_LAT-1:0]     vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[COF_LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld[COF_LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_row
    localparam int R1 = (i + 1) % 3;
    localparam int R2 = (i + 2) % 3;
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int C1 = (j + 1) % 3;
      localparam int C2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          p1[i][j] <= a[R1][C1] * a[R2][C2];
          p2[i][j] <= a[R1][C2] * a[R2][C1];
          c2[i][j] <= CW'(p1[i][j]) - CW'(p2[i][j]);
          c3[i][j] <= c2[i][j];
          cof[i][j] <= c3[i][j];
        end
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (en) begin
        r0_1[j] <= a[0][j];
        r0_2[j] <= r0_1[j];
        dp[j]   <= DW'(r0_2[j]) * DW'(c2[0][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= dp[0] + dp[1] + dp[2];
    end
  end
endmodule

/* rtl/mi3_div_lane.sv */
// one result entry: magnitudes, rounded restoring division one bit a stage, saturation
module mi3_div_lane import mi3_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CW-1:0]    cof,
  input  logic signed [DW-1:0]    det,
  output logic signed [OUT_W-1:0] res,
  output logic                    sing
);
  localparam logic [QB-1:0]    HALF = QB'(1) << (OUT_W - 1);
  localparam logic [QB-1:0]    PMAX = HALF - QB'(1);
  localparam logic [OUT_W-1:0] MAXV = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] MINV = {1'b1, {(OUT_W-1){1'b0}}};

  logic [CW-1:0] mag_c;
  logic [DW-1:0] mag_d;
  logic          neg0, sing0, neg1, sing1;
  logic [TW-1:0] top1;
  logic [RW-1:0] bot1;

  logic [RW-1:0] rem  [QB+1];
  logic [QB-1:0] lo   [QB+1];
  logic [QB-1:0] q    [QB+1];
  logic [RW-1:0] bot  [QB+1];
  logic          ovf  [QB+1];
  logic          neg  [QB+1];
  logic          sng  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_c <= cof[CW-1] ? CW'(-cof) : CW'(cof);
      mag_d <= det[DW-1] ? DW'(-det) : DW'(det);
      neg0  <= cof[CW-1] ^ det[DW-1];
      sing0 <= (det == '0);
      // round to nearest: floor((2n + d) / 2d)
      top1  <= (TW'(mag_c) << (SH + 1)) + TW'(mag_d);
      bot1  <= {mag_d, 1'b0};
      neg1  <= neg0;
      sing1 <= sing0;
      ovf[0] <= (top1 >> QB) >= TW'(bot1);
      rem[0] <= RW'(top1 >> QB);
      lo[0]  <= top1[QB-1:0];
      q[0]   <= '0;
      bot[0] <= bot1;
      neg[0] <= neg1;
      sng[0] <= sing1;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW:0] trial;
    logic        ge;
    assign trial = {rem[k], lo[k][QB-1]};
    assign ge    = trial >= {1'b0, bot[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? RW'(trial - {1'b0, bot[k]}) : RW'(trial);
        lo[k+1]  <= lo[k] << 1;
        q[k+1]   <= {q[k][QB-2:0], ge};
        bot[k+1] <= bot[k];
        ovf[k+1] <= ovf[k];
        neg[k+1] <= neg[k];
        sng[k+1] <= sng[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing <= sng[QB];
      if (sng[QB]) begin
        res <= '0;
      end else if (neg[QB]) begin
        if (ovf[QB] || q[QB] > HALF) res <= MINV;
        else res <= -(q[QB][OUT_W-1:0]);
      end else begin
        if (ovf[QB] || q[QB] > PMAX) res <= MAXV;
        else res <= q[QB][OUT_W-1:0];
      end
    end
  end
endmodule

/* rtl/matrix3_inverse_transpose.sv */
// top level: 3x3 inverse transpose (normal matrix) in fixed point, fully pipelined
// pipeline: 4 cofactor stages, (OUT_W + 5) divide stages, then the output register
// throughput: one matrix per cycle while the output is not stalled; each entry has its own bit-per-stage divider
// the whole pipeline advances while the output register is empty or being taken
// reset: synchronous, active high; clears valid bits only, data registers are not reset
module matrix3_inverse_transpose import mi3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic                  m_tuser    // singular
);
  logic                    en;
  logic signed [IN_W-1:0]  a   [3][3];
  logic signed [CW-1:0]    cof [3][3];
  logic signed [DW-1:0]    det;
  logic                    cof_valid;
  logic signed [OUT_W-1:0] res [9];
  logic                    sing [9];
  logic [LANE_LAT-1:0]     lane_vld;

  // single stall signal for every stage; output register acts as the skid point
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  for (genvar i = 0; i < 3; i++) begin : g_unpack_r
    for (genvar j = 0; j < 3; j++) begin : g_unpack_c
      assign a[i][j] = s_tdata[(i*3+j)*IN_W +: IN_W];
    end
  end

  mi3_cofactor u_cof (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .a         (a),
    .out_valid (cof_valid),
    .cof       (cof),
    .det       (det)
  );

  // nine independent divide lanes, one per entry
  for (genvar n = 0; n < 9; n++) begin : g_lane
    mi3_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .cof  (cof[n/3][n%3]),
      .det  (det),
      .res  (res[n]),
      .sing (sing[n])
    );
  end

  // valid bits following the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_vld <= '0;
    end else if (en) begin
      lane_vld <= {lane_vld[LANE_LAT-2:0], cof_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= lane_vld[LANE_LAT-1];
    end
  end

  for (genvar n = 0; n < 9; n++) begin : g_pack
    always_ff @(posedge clk) begin
      if (en) begin
        m_tdata[n*OUT_W +: OUT_W] <= res[n];
      end
    end
  end

  if (OUT_DATA_W > 9 * OUT_W) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        m_tdata[OUT_DATA_W-1:9*OUT_W] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= sing[0];
    end
  end
endmodule

/* verif/testbench.sv */
// self-checking testbench for the 3x3 inverse transpose (normal matrix) unit
module testbench;
  import mi3_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] entries;
    logic                  singular;
  } normal_t;

  normal_t expected_normals[$];
  int      cycle_count;
  bit      failed;
  bit      sink_stalls;   // when clear the sink is always ready

  localparam int LIMIT = 3000000;

  matrix3_inverse_transpose i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // a00, a01, a02, a10, a11, a12, a20, a21, a22
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // r00 .. r22
    .m_tuser  (m_tuser)    // singular
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // rounded, saturated C * 2^(F+G) / D on exact wide integers
  function automatic normal_t inverse_transpose(logic [IN_DATA_W-1:0] m);
    logic signed [127:0] a [3][3];
    logic signed [127:0] cof [3][3];
    logic signed [127:0] det, num, n, d, q;
    logic signed [127:0] hi_lim, lo_lim;
    normal_t res;
    int i, j;
    hi_lim = (128'sd1 <<< (OUT_W - 1)) - 1;
    lo_lim = -(128'sd1 <<< (OUT_W - 1));
    res = '0;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        a[i][j] = 128'(signed'(m[(i * 3 + j) * IN_W +: IN_W]));
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        cof[i][j] = a[(i + 1) % 3][(j + 1) % 3] * a[(i + 2) % 3][(j + 2) % 3]
                  - a[(i + 1) % 3][(j + 2) % 3] * a[(i + 2) % 3][(j + 1) % 3];
    det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) begin
        num = cof[i][j] <<< SH;
        n = (num < 0) ? -num : num;
        d = (det < 0) ? -det : det;
        q = (2 * n + d) / (2 * d);   // ties away from zero on magnitudes
        if ((num < 0) != (det < 0)) q = -q;
        if (q > hi_lim) q = hi_lim;
        if (q < lo_lim) q = lo_lim;
        res.entries[(i * 3 + j) * OUT_W +: OUT_W] = q[OUT_W-1:0];
      end
    return res;
  endfunction

  // called at a falling edge; valid stays up when the next beat follows with no gap
  task automatic send_matrix(input logic [IN_DATA_W-1:0] m);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= m;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_normals.push_back(inverse_transpose(m));
    @(negedge clk);
  endtask

  // builds a matrix from nine entries, a00 first
  function automatic logic [IN_DATA_W-1:0] pack9(logic [15:0] e0, e1, e2, e3, e4, e5,
                                                  e6, e7, e8);
    pack9 = '0;
    pack9[143:0] = {e8, e7, e6, e5, e4, e3, e2, e1, e0};
  endfunction

  // sink: random stalls per beat while sink_stalls is set, compare against oldest expectation
  initial begin
    int wait_cycles;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      wait_cycles = sink_stalls ? $urandom_range(0, 13) : 0;
      if (wait_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (expected_normals.size() == 0) begin
        $error("result beat with no expectation waiting");
        failed = 1'b1;
      end else begin
        normal_t exp_n;
        exp_n = expected_normals.pop_front();
        for (int k = 0; k < 9; k++)
          if (m_tdata[k * OUT_W +: OUT_W] !== exp_n.entries[k * OUT_W +: OUT_W]) begin
            $error("r%0d%0d expected %0d actual %0d", k / 3, k % 3,
                   $signed(exp_n.entries[k * OUT_W +: OUT_W]),
                   $signed(m_tdata[k * OUT_W +: OUT_W]));
            failed = 1'b1;
          end
        if (m_tuser !== exp_n.singular) begin
          $error("singular expected %0b actual %0b", exp_n.singular, m_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT) begin
        $display("matrix3_inverse_transpose regression: fail");
        $finish;
      end
    end
  end

  // extremes, identity, scaled and singular matrices
  task automatic test_directed();
    send_matrix(pack9(16'h1000, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000));
    send_matrix(pack9(16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff));
    send_matrix(pack9(16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000));
    send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));           // tiny det, large result
    send_matrix(pack9(16'hffff, 0, 0, 0, 1, 0, 0, 0, 1));    // negative det
    send_matrix(pack9(0, 0, 0, 0, 0, 0, 0, 0, 0));           // all zero, singular
    send_matrix(pack9(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_matrix(pack9(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                      16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    send_matrix(pack9(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h7fff));
    send_matrix(pack9(16'h1000, 16'h2000, 16'h3000, 16'h2000, 16'h4000,
                      16'h6000, 1, 2, 3));                   // dependent rows
    send_matrix(pack9(0, 16'h1000, 0, 16'h1000, 0, 0, 0, 0, 16'h1000));  // swap
    send_matrix(pack9(16'h2000, 16'h0800, 0, 16'hf800, 16'h2000, 0, 0, 0, 16'h0800));
    send_matrix(pack9(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005,
                      16'h0006, 16'h0007, 16'h0008, 16'h000a));
  endtask

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 5))
      0: rand_entry = 16'($urandom_range(0, 15)) - 16'd8;     // near zero
      1: rand_entry = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: rand_entry = 16'($urandom_range(0, 8191)) - 16'd4096;
      default: rand_entry = 16'($urandom);
    endcase
  endfunction

  task automatic test_random(int count);
    logic [IN_DATA_W-1:0] m;
    for (int n = 0; n < count; n++) begin
      m = '0;
      for (int k = 0; k < 9; k++) m[k * IN_W +: IN_W] = rand_entry();
      // some rank-deficient matrices: repeat or zero a row
      if ($urandom_range(0, 9) == 0) m[2 * 3 * IN_W +: 3 * IN_W] = m[0 +: 3 * IN_W];
      else if ($urandom_range(0, 19) == 0) m[IN_W * 3 +: 3 * IN_W] = '0;
      send_matrix(m);
    end
  endtask

  // back-to-back beats with an always-ready sink
  task automatic test_full_rate(int count);
    logic [IN_DATA_W-1:0] m;
    sink_stalls = 1'b0;
    for (int n = 0; n < count; n++) begin
      m = '0;
      for (int k = 0; k < 9; k++) m[k * IN_W +: IN_W] = rand_entry();
      s_tvalid <= 1'b1;
      s_tdata  <= m;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      expected_normals.push_back(inverse_transpose(m));
      @(negedge clk);
    end
    s_tvalid <= 1'b0;
    sink_stalls = 1'b1;
  endtask

  initial begin
    failed      = 1'b0;
    sink_stalls = 1'b1;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(1700);
    test_full_rate(200);
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed)
      $display("matrix3_inverse_transpose regression: pass");
    else
      $display("matrix3_inverse_transpose regression: fail");
    $finish;
  end

endmodule
